// ===== hdl/gf2cpv_pkg.sv =====
// gf2cpv_pkg: shared types and constants of the gf2 codeword pair verify unit
// no dependencies; imported by every design module except the checker

package gf2cpv_pkg;

  // fixed field widths of the transaction ports
  localparam int DataWidth  = 32;
  localparam int IndexWidth = 4;

  // code bits of a pair that fail the check
  localparam logic [1:0] PairBothSet = 2'b11;

  // operation codes
  typedef enum logic {
    OpLoad   = 1'b0,
    OpColumn = 1'b1
  } op_e;

  // one accepted input transaction
  typedef struct packed {
    op_e                   operation;
    logic [IndexWidth-1:0] word_index;
    logic [DataWidth-1:0]  data_word;
    logic                  column_end;
    logic                  mask_bit;
    logic                  vector_end;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic code_bit;
    logic pair_bad;
    logic all_ok;
    logic last;
  } result_t;

endpackage

// ===== hdl/gf2cpv_in_stage.sv =====
// gf2cpv_in_stage: input register of the verify unit
// depends on gf2cpv_pkg (item_t)

module gf2cpv_in_stage
  import gf2cpv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // stall only while a held transaction cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/gf2cpv_core.sv =====
// gf2cpv_core: vector word store, parity accumulation and pair check
// depends on gf2cpv_pkg (item_t, result_t, op_e, PairBothSet)

module gf2cpv_core
  import gf2cpv_pkg::*;
#(
  parameter int WORD_BITS    = 32,
  parameter int VECTOR_WORDS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    fire_i,
  output logic    res_valid_o,
  output result_t res_o
);

  // only bits and entries reachable through the fixed-width ports are kept
  localparam int UsedBits   = (WORD_BITS < DataWidth) ? WORD_BITS : DataWidth;
  localparam int MaxEntries = 1 << IndexWidth;
  localparam int StoreDepth = (VECTOR_WORDS < MaxEntries) ? VECTOR_WORDS : MaxEntries;
  localparam int AddrWidth  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [IndexWidth:0] DepthLimit = (IndexWidth + 1)'(StoreDepth);

  logic [UsedBits-1:0] store_q [StoreDepth];

  logic parity_acc_q, parity_acc_d;
  logic odd_q, odd_d;
  logic first_q, first_d;
  logic ok_q, ok_d;

  logic                 in_range;
  logic [AddrWidth-1:0] addr;
  logic [UsedBits-1:0]  col_word;
  logic [UsedBits-1:0]  vec_word;
  logic                 acc;
  logic                 bit_c;
  logic                 bad;
  logic                 ok_out;
  logic                 is_column;

  assign in_range  = {1'b0, item_i.word_index} < DepthLimit;
  assign addr      = item_i.word_index[AddrWidth-1:0];
  assign col_word  = item_i.data_word[UsedBits-1:0];
  assign vec_word  = in_range ? store_q[addr] : '0;
  assign is_column = (item_i.operation == OpColumn);

  // parity of this word folded into the running column parity
  assign acc    = parity_acc_q ^ (^(vec_word & col_word));
  assign bit_c  = acc ^ item_i.mask_bit;
  assign bad    = odd_q && ({first_q, bit_c} == PairBothSet);
  assign ok_out = ok_q && !bad;

  // next state of the pair tracking
  always_comb begin
    parity_acc_d = parity_acc_q;
    odd_d        = odd_q;
    first_d      = first_q;
    ok_d         = ok_q;
    if (fire_i && is_column) begin
      if (!item_i.column_end) begin
        parity_acc_d = acc;
      end else begin
        parity_acc_d = 1'b0;
        if (!odd_q) begin
          odd_d   = 1'b1;
          first_d = bit_c;
        end else begin
          odd_d   = 1'b0;
          first_d = 1'b0;
          ok_d    = ok_out;
        end
        if (item_i.vector_end) begin
          odd_d   = 1'b0;
          first_d = 1'b0;
          ok_d    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_acc_q <= 1'b0;
      odd_q        <= 1'b0;
      first_q      <= 1'b0;
      ok_q         <= 1'b1;
    end else begin
      parity_acc_q <= parity_acc_d;
      odd_q        <= odd_d;
      first_q      <= first_d;
      ok_q         <= ok_d;
    end
  end

  // vector store write, loads beyond the store are dropped
  always_ff @(posedge clk_i) begin
    if (fire_i && !is_column && in_range) begin
      store_q[addr] <= col_word;
    end
  end

  // result of a column's last word
  assign res_valid_o    = is_column && item_i.column_end;
  assign res_o.code_bit = bit_c;
  assign res_o.pair_bad = bad;
  assign res_o.all_ok   = ok_out;
  assign res_o.last     = item_i.vector_end;

endmodule

// ===== hdl/gf2cpv_out_stage.sv =====
// gf2cpv_out_stage: result register toward the receiver
// depends on gf2cpv_pkg (result_t)

module gf2cpv_out_stage
  import gf2cpv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // register can take a new result when empty or being drained
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/gf2_codeword_pair_verify_unit.sv =====
// gf2_codeword_pair_verify_unit: top level of the gf2 codeword pair verify unit
// depends on gf2cpv_pkg, gf2cpv_in_stage, gf2cpv_core, gf2cpv_out_stage
//
// Usage: first load the vector (message or signature) word by word with
// operation = load, then stream the matrix columns word by word with
// operation = column, word_index naming the vector word each column word
// pairs with and column_end on the last word of a column. Each column end
// gives one result transaction: code_bit = parity(vector AND column) XOR
// mask_bit, pair_bad on the second column of a pair whose bits are 11,
// all_ok as the sticky verdict and last copied from vector_end. After the
// final column the pair tracking and verdict return to their reset values.
// Timing: an input transaction is registered, handled by one AND plus
// xor-reduce and pair logic, and its result registered in the result
// register, where the receiver takes it. One transaction is taken per
// cycle unless a column end is held behind a stalled receiver.
// Reset clears the pipeline valids, the parity and pair tracking and sets
// the verdict; the vector store is not cleared and must be loaded first.
// When the receiver stalls, the result register holds and the input stage
// stalls only once it holds a column end that cannot move on.

module gf2_codeword_pair_verify_unit
  import gf2cpv_pkg::*;
#(
  parameter int WORD_BITS    = 32,
  parameter int VECTOR_WORDS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [IndexWidth-1:0] word_index_i,
  input  logic [DataWidth-1:0]  data_word_i,
  input  logic                  column_end_i,
  input  logic                  mask_bit_i,
  input  logic                  vector_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  code_bit_o,
  output logic                  pair_bad_o,
  output logic                  all_ok_o,
  output logic                  last_o
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    out_free;

  assign in_item.operation  = op_e'(operation_i);
  assign in_item.word_index = word_index_i;
  assign in_item.data_word  = data_word_i;
  assign in_item.column_end = column_end_i;
  assign in_item.mask_bit   = mask_bit_i;
  assign in_item.vector_end = vector_end_i;

  // held transaction moves on unless its result has nowhere to go
  assign advance = s1_valid && (!res_valid || out_free);

  gf2cpv_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  gf2cpv_core #(
    .WORD_BITS    (WORD_BITS),
    .VECTOR_WORDS (VECTOR_WORDS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (s1_item),
    .fire_i      (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gf2cpv_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign code_bit_o = out_res.code_bit;
  assign pair_bad_o = out_res.pair_bad;
  assign all_ok_o   = out_res.all_ok;
  assign last_o     = out_res.last;

endmodule

// ===== hdl/gf2cpv_checker.sv =====
// gf2cpv_checker: port-level assertions for the verify unit, bound to the top
// depends on gf2_codeword_pair_verify_unit ports only

module gf2cpv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic code_bit_o,
  input logic pair_bad_o,
  input logic all_ok_o,
  input logic last_o
);

  // a stalled result transaction stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(code_bit_o) && $stable(pair_bad_o) && $stable(all_ok_o) && $stable(last_o))
    else $error("result changed while stalled");

  // a failed pair always clears the verdict it reports
  a_bad_clears_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_bad_o |-> !all_ok_o)
    else $error("pair_bad with all_ok set");

  // a failed pair ends in a set code bit
  a_bad_needs_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_bad_o |-> code_bit_o)
    else $error("pair_bad with code_bit clear");

endmodule

bind gf2_codeword_pair_verify_unit gf2cpv_checker u_gf2cpv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .code_bit_o  (code_bit_o),
  .pair_bad_o  (pair_bad_o),
  .all_ok_o    (all_ok_o),
  .last_o      (last_o)
);

// ===== tb/sv/gf2_codeword_pair_verify_unit_test.sv =====
// gf2_codeword_pair_verify_unit_test: self-checking testbench of the codeword pair verify unit
// depends on gf2cpv_pkg and gf2_codeword_pair_verify_unit; a scoreboard class predicts each
// code bit, pair check and verdict, random bursts and stalls drive both handshakes

module gf2_codeword_pair_verify_unit_test;
  import gf2cpv_pkg::*;

  localparam int          VecWords   = 16;
  localparam int unsigned ItemTarget = 1225;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 8;

  // expected results of the column stream, kept in acceptance order
  class codeword_board;
    logic [DataWidth-1:0] vector_words [VecWords];
    logic                 parity_run;
    logic                 odd_col;
    logic                 first_bit;
    logic                 verdict_ok;
    result_t              pending_bits [$];
    int unsigned          fail_count;
    int unsigned          results_checked;

    function new();
      parity_run      = 1'b0;
      odd_col         = 1'b0;
      first_bit       = 1'b0;
      verdict_ok      = 1'b1;
      fail_count      = 0;
      results_checked = 0;
    endfunction

    // update the store or the column state for one accepted transaction
    function void take_item(item_t it);
      logic    bit_now;
      logic    bad;
      result_t outcome;
      if (it.operation == OpLoad) begin
        if (it.word_index < VecWords) vector_words[it.word_index] = it.data_word;
        return;
      end
      if (it.word_index < VecWords) begin
        parity_run = parity_run ^ (^(vector_words[it.word_index] & it.data_word));
      end
      if (!it.column_end) return;
      bit_now    = parity_run ^ it.mask_bit;
      parity_run = 1'b0;
      bad        = 1'b0;
      // pair tracking over even and odd columns
      if (!odd_col) begin
        first_bit = bit_now;
        odd_col   = 1'b1;
      end else begin
        bad = ({first_bit, bit_now} == PairBothSet);
        if (bad) verdict_ok = 1'b0;
        odd_col   = 1'b0;
        first_bit = 1'b0;
      end
      outcome.code_bit = bit_now;
      outcome.pair_bad = bad;
      outcome.all_ok   = verdict_ok;
      outcome.last     = it.vector_end;
      pending_bits.push_back(outcome);
      // codeword done, back to the start of a pair with a clean verdict
      if (it.vector_end) begin
        odd_col    = 1'b0;
        first_bit  = 1'b0;
        verdict_ok = 1'b1;
      end
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      results_checked++;
      if (pending_bits.size() == 0) begin
        $error("result with no expectation: code_bit %0b pair_bad %0b all_ok %0b last %0b",
               got.code_bit, got.pair_bad, got.all_ok, got.last);
        fail_count++;
        return;
      end
      want = pending_bits.pop_front();
      if (got.code_bit !== want.code_bit) begin
        $error("code_bit expected %0b actual %0b", want.code_bit, got.code_bit);
        fail_count++;
      end
      if (got.pair_bad !== want.pair_bad) begin
        $error("pair_bad expected %0b actual %0b", want.pair_bad, got.pair_bad);
        fail_count++;
      end
      if (got.all_ok !== want.all_ok) begin
        $error("all_ok expected %0b actual %0b", want.all_ok, got.all_ok);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0b actual %0b", want.last, got.last);
        fail_count++;
      end
    endfunction

    function bit drained();
      return pending_bits.size() == 0;
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  operation_i;
  logic [IndexWidth-1:0] word_index_i;
  logic [DataWidth-1:0]  data_word_i;
  logic                  column_end_i;
  logic                  mask_bit_i;
  logic                  vector_end_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  code_bit_o;
  logic                  pair_bad_o;
  logic                  all_ok_o;
  logic                  last_o;

  codeword_board board;
  int unsigned   items_sent;
  int unsigned   burst_left;
  int unsigned   cycle_count;

  gf2_codeword_pair_verify_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .word_index_i (word_index_i),
    .data_word_i  (data_word_i),
    .column_end_i (column_end_i),
    .mask_bit_i   (mask_bit_i),
    .vector_end_i (vector_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_bit_o   (code_bit_o),
    .pair_bad_o   (pair_bad_o),
    .all_ok_o     (all_ok_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // data word with a bias toward the extremes
  function automatic logic [DataWidth-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, DataWidth - 1);
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction, wait for acceptance, then maybe pause between bursts
  task automatic send_item(input op_e op, input logic [IndexWidth-1:0] idx,
                           input logic [DataWidth-1:0] data, input logic ce,
                           input logic mb, input logic ve);
    item_t       it;
    int unsigned gap;
    it.operation  = op;
    it.word_index = idx;
    it.data_word  = data;
    it.column_end = ce;
    it.mask_bit   = mb;
    it.vector_end = ve;
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    word_index_i <= idx;
    data_word_i  <= data;
    column_end_i <= ce;
    mask_bit_i   <= mb;
    vector_end_i <= ve;
    do @(posedge clk_i); while (in_stall_o);
    board.take_item(it);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // one codeword of columns, mostly an even count, some odd
  task automatic send_codeword();
    int unsigned ncols;
    int unsigned nwords;
    logic        col_done;
    if ($urandom_range(0, 6) == 0) ncols = 2 * $urandom_range(0, 5) + 1;
    else ncols = 2 * $urandom_range(1, 6);
    for (int c = 0; c < ncols; c++) begin
      nwords = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
      for (int w = 0; w < nwords; w++) begin
        col_done = (w == nwords - 1);
        send_item(OpColumn, IndexWidth'($urandom_range(0, VecWords - 1)), pick_word(),
                  col_done, 1'($urandom_range(0, 1)), col_done && (c == ncols - 1));
      end
    end
  endtask

  // receiver stall pattern, with one long hold-off to back up the pipeline
  initial begin : stall_pattern
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk_i);
        if (!held && board.results_checked >= 120) begin
          held = 1'b1;
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= (cycle_count % 3 == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result({code_bit_o, pair_bad_o, all_ok_o, last_o});
    end
  end

  // watchdog on the cycle count
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("gf2_codeword_pair_verify_unit verification failed");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned kind;
    int unsigned nloads;
    board        = new();
    items_sent   = 0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OpLoad;
    word_index_i = '0;
    data_word_i  = '0;
    column_end_i = 1'b0;
    mask_bit_i   = 1'b0;
    vector_end_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // load every vector word, extremes first
    send_item(OpLoad, 4'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    send_item(OpLoad, 4'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_item(OpLoad, 4'd2, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
    send_item(OpLoad, 4'd3, 32'h0000_0001, 1'b1, 1'b1, 1'b1);
    for (int i = 4; i < VecWords; i++) begin
      send_item(OpLoad, IndexWidth'(i), $urandom, 1'b0, 1'b0, 1'b0);
    end
    // zero vector word: the bit is the mask alone, then an even parity of all ones
    send_item(OpColumn, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    send_item(OpColumn, 4'd1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    // top and bottom bit set give a pair 11
    send_item(OpColumn, 4'd2, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
    send_item(OpColumn, 4'd3, 32'h0000_0001, 1'b1, 1'b0, 1'b0);
    // two-word column that closes the codeword on an odd count
    send_item(OpColumn, 4'd1, 32'h0000_0001, 1'b0, 1'b1, 1'b0);
    send_item(OpColumn, 4'd2, 32'h8000_0000, 1'b1, 1'b0, 1'b1);
    // final mark on a word that does not end its column
    send_item(OpColumn, 4'd1, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    send_item(OpColumn, 4'd3, 32'h0000_0001, 1'b1, 1'b0, 1'b0);
    send_item(OpColumn, 4'd3, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);

    // random codewords, vector reloads and noise
    while (items_sent < ItemTarget) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        send_codeword();
      end else if (kind == 8) begin
        nloads = $urandom_range(1, VecWords);
        repeat (nloads) begin
          send_item(OpLoad, IndexWidth'($urandom_range(0, VecWords - 1)), pick_word(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end else begin
        send_item(op_e'($urandom_range(0, 1)), IndexWidth'($urandom_range(0, VecWords - 1)),
                  pick_word(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
    in_valid_i <= 1'b0;

    // drain, then watch a few cycles for stray results
    while (!board.drained()) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.fail_count == 0 && board.drained()) begin
      $display("gf2_codeword_pair_verify_unit verification clean");
    end else begin
      $display("gf2_codeword_pair_verify_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== gf2_codeword_pair_verify_unit.f =====
hdl/gf2cpv_pkg.sv
hdl/gf2cpv_in_stage.sv
hdl/gf2cpv_core.sv
hdl/gf2cpv_out_stage.sv
hdl/gf2_codeword_pair_verify_unit.sv
hdl/gf2cpv_checker.sv
tb/sv/gf2_codeword_pair_verify_unit_test.sv
